@@ rtl/glfbr_pkg.sv @@
// Shared types, codes and constants of the graphic LCD frame buffer refresh block.
`timescale 1ns / 1ps

package glfbr_pkg;

    // Default panel geometry.
    localparam int WIDTH_DEFAULT        = 128;
    localparam int ROWS_DEFAULT         = 64;
    localparam int CHIP_COLUMNS_DEFAULT = 64;

    // Rows held in one store byte, and setup writes before the data of a page.
    localparam int PAGE_ROWS    = 8;
    localparam int SETUP_WRITES = 6;

    // Fixed field widths.
    localparam int COLUMN_W = 7;
    localparam int ROW_W    = 6;
    localparam int IPAGE_W  = 3;
    localparam int BYTE_W   = 8;
    localparam int STEP_W   = 8;
    localparam int OFFC_W   = 9;
    localparam int OFFP_W   = 5;
    localparam int CFG_W    = 9;

    typedef enum logic [1:0] {
        OP_SET_PIXEL = 2'd0,
        OP_FILL      = 2'd1,
        OP_IMAGE     = 2'd2,
        OP_TICK      = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_PAGE   = 2'd1,
        KIND_COLUMN = 2'd2,
        KIND_START  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        REG_REFRESH_HOLD  = 2'd0,
        REG_OFFSET_COLUMN = 2'd1,
        REG_OFFSET_PAGE   = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIXEL,
        ST_IMAGE,
        ST_TICK,
        ST_FILL
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic pixel;
        logic image;
        logic tick;
        logic fill;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_last;
    } status_t;

endpackage

@@ rtl/glfbr_ctrl.sv @@
// Controller state machine of the graphic LCD frame buffer refresh block.
`timescale 1ns / 1ps

module glfbr_ctrl
    import glfbr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] operation,
    input  status_t    status,
    output logic       busy,
    output cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            // The store is cleared by a fill sweep straight after reset.
            state_reg <= ST_FILL;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (op_t'(operation))
                        OP_SET_PIXEL: state_next = ST_PIXEL;
                        OP_FILL:      state_next = ST_FILL;
                        OP_IMAGE:     state_next = ST_IMAGE;
                        OP_TICK:      state_next = ST_TICK;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_PIXEL: state_next = ST_IDLE;
            ST_IMAGE: state_next = ST_IDLE;
            ST_TICK:  state_next = ST_IDLE;
            ST_FILL:
            begin
                if (status.fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy       = (state_reg != ST_IDLE);
        cmd.accept = (state_reg == ST_IDLE) && start;
        cmd.pixel  = (state_reg == ST_PIXEL);
        cmd.image  = (state_reg == ST_IMAGE);
        cmd.tick   = (state_reg == ST_TICK);
        cmd.fill   = (state_reg == ST_FILL);
    end

    // An accepted word always makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) cmd.accept |=> busy)
        else $error("accepted word did not make the block busy");

    // A fill sweep only ends on its last store address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fill && !status.fill_last) |=> cmd.fill)
        else $error("fill sweep left before its last address");

    // Pixel, image and tick operations return to idle at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pixel || cmd.image || cmd.tick) |=> !busy)
        else $error("single-cycle operation did not return to idle");

endmodule

@@ rtl/glfbr_datapath.sv @@
// Datapath of the graphic LCD frame buffer refresh block: frame store, refresh counters, outputs.
`timescale 1ns / 1ps

module glfbr_datapath
    import glfbr_pkg::*;
#(
    parameter int WIDTH        = WIDTH_DEFAULT,
    parameter int ROWS         = ROWS_DEFAULT,
    parameter int CHIP_COLUMNS = CHIP_COLUMNS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic [1:0]          operation,
    input  logic [COLUMN_W-1:0] column,
    input  logic [ROW_W-1:0]    row,
    input  logic [IPAGE_W-1:0]  image_page,
    input  logic                color,
    input  logic [BYTE_W-1:0]   data_byte,
    output logic                result_strobe,
    output logic [1:0]          controller,
    output logic [1:0]          write_kind,
    output logic [BYTE_W-1:0]   value,
    output logic                end_of_page
);

    localparam int PAGES      = ROWS / PAGE_ROWS;
    localparam int STORE_SIZE = WIDTH * PAGES;
    localparam int ADDR_W     = $clog2(STORE_SIZE);
    localparam int STEP_LAST  = SETUP_WRITES + WIDTH - 1;

    // Configuration registers.
    logic              hold_reg;
    logic [OFFC_W-1:0] off_col_reg;
    logic [OFFP_W-1:0] off_page_reg;

    // Words latched on acceptance.
    logic [COLUMN_W-1:0] col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [IPAGE_W-1:0]  ipage_reg;
    logic                color_reg;
    logic [BYTE_W-1:0]   data_reg;
    logic [BYTE_W-1:0]   fill_data_reg;

    // Refresh position and fill sweep.
    logic [IPAGE_W-1:0] page_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [ADDR_W-1:0]  fill_addr_reg;

    // Frame store.
    logic [BYTE_W-1:0] store_mem [STORE_SIZE];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;

    // Output registers.
    logic              strobe_reg;
    logic              strobe_next;
    logic [1:0]        controller_reg;
    logic [1:0]        controller_next;
    kind_t             kind_reg;
    kind_t             kind_next;
    logic [BYTE_W-1:0] value_reg;
    logic [BYTE_W-1:0] value_next;
    logic              eop_reg;
    logic              eop_next;

    logic [STEP_W-1:0]  step_next;
    logic [IPAGE_W-1:0] page_next;

    logic [STEP_W-1:0] tick_col;
    logic [STEP_W-1:0] col_raw;
    logic [ADDR_W-1:0] port_pix_addr;
    logic [ADDR_W-1:0] tick_addr;
    logic [ADDR_W-1:0] pix_addr;
    logic              pix_valid;
    logic [BYTE_W-1:0] pix_mask;
    logic signed [9:0] img_col;
    logic signed [5:0] img_page;
    logic [ADDR_W-1:0] img_addr;
    logic              img_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg     <= 1'b0;
            off_col_reg  <= '0;
            off_page_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(cfg_index))
                REG_REFRESH_HOLD:  hold_reg     <= cfg_data[0];
                REG_OFFSET_COLUMN: off_col_reg  <= cfg_data[OFFC_W-1:0];
                REG_OFFSET_PAGE:   off_page_reg <= cfg_data[OFFP_W-1:0];
                default:           hold_reg     <= hold_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            col_reg   <= column;
            row_reg   <= row;
            ipage_reg <= image_page;
            color_reg <= color;
            data_reg  <= data_byte;
        end
    end

    // The fill pattern is zero after reset so that the first sweep clears the store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_data_reg <= '0;
            fill_addr_reg <= '0;
        end
        else
        begin
            if (cmd.accept && (op_t'(operation) == OP_FILL))
            begin
                fill_data_reg <= data_byte;
            end
            if (cmd.fill)
            begin
                fill_addr_reg <= status.fill_last ? '0 : fill_addr_reg + 1'b1;
            end
        end
    end

    assign status.fill_last = (fill_addr_reg == ADDR_W'(STORE_SIZE - 1));

    // Read address: ports for a set pixel, else the refresh position; the byte is ready next cycle.
    always_comb
    begin
        col_raw  = step_reg - STEP_W'(SETUP_WRITES);
        tick_col = (step_reg < STEP_W'(SETUP_WRITES)) ? '0 : col_raw;
        if (tick_col >= STEP_W'(WIDTH))
        begin
            tick_col = STEP_W'(WIDTH - 1);
        end
        tick_addr = ADDR_W'(ADDR_W'(page_reg) * ADDR_W'(WIDTH)) + ADDR_W'(tick_col);
        port_pix_addr = ADDR_W'(ADDR_W'(row[ROW_W-1:3]) * ADDR_W'(WIDTH))
                      + ADDR_W'(column);
        rd_addr = (op_t'(operation) == OP_SET_PIXEL) ? port_pix_addr : tick_addr;
    end

    // Write side for fill sweeps, and for pixel and image operations from the latched word.
    always_comb
    begin
        pix_addr  = ADDR_W'(ADDR_W'(row_reg[ROW_W-1:3]) * ADDR_W'(WIDTH))
                  + ADDR_W'(col_reg);
        pix_valid = ({1'b0, col_reg} < 8'(WIDTH)) && ({1'b0, row_reg} < 7'(ROWS));
        pix_mask  = BYTE_W'(1) << row_reg[2:0];

        img_col   = $signed({3'b000, col_reg}) + $signed({off_col_reg[OFFC_W-1], off_col_reg});
        img_page  = $signed({3'b000, ipage_reg})
                  + $signed({off_page_reg[OFFP_W-1], off_page_reg});
        img_valid = ({1'b0, col_reg} < 8'(WIDTH)) && ({1'b0, ipage_reg} < 4'(PAGES))
                  && !img_col[9] && (img_col[8:0] < 9'(WIDTH))
                  && !img_page[5] && (img_page[4:0] < 5'(PAGES));
        img_addr  = ADDR_W'(ADDR_W'(img_page[2:0]) * ADDR_W'(WIDTH)) + ADDR_W'(img_col[7:0]);

        wr_en   = 1'b0;
        wr_addr = fill_addr_reg;
        wr_data = fill_data_reg;
        if (cmd.fill)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.pixel)
        begin
            wr_en   = pix_valid;
            wr_addr = pix_addr;
            wr_data = color_reg ? (rd_data_reg | pix_mask) : (rd_data_reg & ~pix_mask);
        end
        else if (cmd.image)
        begin
            wr_en   = img_valid;
            wr_addr = img_addr;
            wr_data = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= store_mem[rd_addr];
    end

    // Refresh sequencer: one controller write per tick that is not held.
    always_comb
    begin
        strobe_next     = 1'b0;
        controller_next = controller_reg;
        kind_next       = kind_reg;
        value_next      = value_reg;
        eop_next        = 1'b0;
        step_next       = step_reg;
        page_next       = page_reg;
        if (cmd.tick && !hold_reg)
        begin
            strobe_next = 1'b1;
            value_next  = '0;
            step_next   = step_reg + 1'b1;
            case (step_reg)
                8'd0:
                begin
                    controller_next = 2'd0;
                    kind_next       = KIND_PAGE;
                    value_next      = BYTE_W'(page_reg);
                end
                8'd1:
                begin
                    controller_next = 2'd0;
                    kind_next       = KIND_COLUMN;
                end
                8'd2:
                begin
                    controller_next = 2'd1;
                    kind_next       = KIND_PAGE;
                    value_next      = BYTE_W'(page_reg);
                end
                8'd3:
                begin
                    controller_next = 2'd1;
                    kind_next       = KIND_COLUMN;
                end
                8'd4:
                begin
                    controller_next = 2'd0;
                    kind_next       = KIND_START;
                end
                8'd5:
                begin
                    controller_next = 2'd1;
                    kind_next       = KIND_START;
                end
                default:
                begin
                    kind_next  = KIND_DATA;
                    value_next = rd_data_reg;
                    if (tick_col >= STEP_W'(2 * CHIP_COLUMNS))
                    begin
                        controller_next = 2'd2;
                    end
                    else if (tick_col >= STEP_W'(CHIP_COLUMNS))
                    begin
                        controller_next = 2'd1;
                    end
                    else
                    begin
                        controller_next = 2'd0;
                    end
                    if (tick_col == STEP_W'(WIDTH - 1))
                    begin
                        eop_next  = 1'b1;
                        step_next = '0;
                        page_next = (page_reg >= IPAGE_W'(PAGES - 1)) ? '0 : page_reg + 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
            step_reg   <= '0;
            page_reg   <= '0;
        end
        else
        begin
            strobe_reg <= strobe_next;
            step_reg   <= step_next;
            page_reg   <= page_next;
        end
    end

    always_ff @(posedge clk)
    begin
        controller_reg <= controller_next;
        kind_reg       <= kind_next;
        value_reg      <= value_next;
        eop_reg        <= eop_next;
    end

    assign result_strobe = strobe_reg;
    assign controller    = controller_reg;
    assign write_kind    = kind_reg;
    assign value         = value_reg;
    assign end_of_page   = eop_reg;

    // A result only follows a refresh tick.
    assert property (@(posedge clk) disable iff (!rst_n) strobe_reg |-> $past(cmd.tick))
        else $error("result word without a refresh tick");

    // The last byte of a page is a data byte and leaves the step at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && eop_reg) |-> (kind_reg == KIND_DATA) && (step_reg == '0))
        else $error("end of page on a wrong word or step not restarted");

    // The refresh step never runs past the last data byte.
    assert property (@(posedge clk) disable iff (!rst_n) step_reg <= STEP_W'(STEP_LAST))
        else $error("refresh step out of range");

endmodule

@@ rtl/graphic_lcd_frame_buffer_refresh.sv @@
// Top level of the graphic LCD frame buffer refresh block.
`timescale 1ns / 1ps

// Channel        Ports                                              Handshake
// -------------  -------------------------------------------------  ----------------------------
// command in     operation, column, row, image_page, color,          start high while busy low
//                data_byte
// result out     controller, write_kind, value, end_of_page          result_strobe, one cycle
// configuration  cfg_index, cfg_data                                 cfg_write, no wait
//
// A set pixel, an image byte and a refresh tick each pass through their own busy state.
// The store byte is read at acceptance. In the following cycle it is written back through the
// single write port of the frame store, or loaded into the result registers. A refresh write
// is therefore shown in the cycle after that. A fill writes one store byte a cycle.
// After reset the same sweep clears the store, busy staying high, before the first word is
// taken. Configuration writes are taken at any time. Results cannot be stalled: each is shown
// for exactly one cycle.

module graphic_lcd_frame_buffer_refresh
    import glfbr_pkg::*;
#(
    parameter int WIDTH        = WIDTH_DEFAULT,
    parameter int ROWS         = ROWS_DEFAULT,
    parameter int CHIP_COLUMNS = CHIP_COLUMNS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          operation,
    input  logic [COLUMN_W-1:0] column,
    input  logic [ROW_W-1:0]    row,
    input  logic [IPAGE_W-1:0]  image_page,
    input  logic                color,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic                cfg_write,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    output logic                result_strobe,
    output logic [1:0]          controller,
    output logic [1:0]          write_kind,
    output logic [BYTE_W-1:0]   value,
    output logic                end_of_page
);

    // Commands and status between the controller and the datapath.
    cmd_t    cmd;
    status_t status;

    // The controller sequences each accepted word through its states.
    glfbr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .status    (status),
        .busy      (busy),
        .cmd       (cmd)
    );

    // The datapath holds the frame store, the refresh position and the result word.
    glfbr_datapath #(
        .WIDTH        (WIDTH),
        .ROWS         (ROWS),
        .CHIP_COLUMNS (CHIP_COLUMNS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .operation     (operation),
        .column        (column),
        .row           (row),
        .image_page    (image_page),
        .color         (color),
        .data_byte     (data_byte),
        .result_strobe (result_strobe),
        .controller    (controller),
        .write_kind    (write_kind),
        .value         (value),
        .end_of_page   (end_of_page)
    );

endmodule
